### design/hrs_pkg.sv
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared types and constants for the health restart supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package hrs_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_FAILURE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_DELAY        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RESTARTS      = 2'd2;

    localparam logic [7:0]  RESET_FAILURE_THRESHOLD = 8'd3;
    localparam logic [31:0] RESET_BOOT_DELAY        = 32'd60000;
    localparam logic [7:0]  RESET_MAX_RESTARTS      = 8'd5;

    localparam logic [15:0] RESTART_TOTAL_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_MONITOR  = 3'd1,
        MODE_RESTART  = 3'd2,
        MODE_COOLDOWN = 3'd3,
        MODE_LOCKED   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ACT_REPORT       = 3'd0,
        ACT_RESTART_DONE = 3'd1,
        ACT_TICK         = 3'd2,
        ACT_SET_ENABLE   = 3'd3,
        ACT_RESET        = 3'd4
    } action_t;

    typedef struct packed {
        logic [2:0]  action;
        logic        report_valid;
        logic        target_up;
        logic [15:0] fail_streak;
        logic [31:0] success_time;
        logic [31:0] fail_time;
        logic [31:0] now_time;
        logic        enable_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        is_enabled;
        logic        restart_pending;
        logic [15:0] failure_count;
        logic [15:0] restarts_done;
        logic [31:0] last_success;
        logic [31:0] last_failure;
        logic [31:0] last_restart;
        logic [31:0] lockout_time;
    } status_t;

endpackage

`default_nettype wire

### design/health_restart_supervisor.sv
// ----------------------------------------------------------------------------
// health_restart_supervisor
// Decides when a monitored target must be power-cycled, one event per beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         one event: action in tuser, report and times in tdata
//  m_axis    out        full status after the event, one beat per event
//  cfg       in         write-only register port, three registers
//
//  One event is accepted per cycle while the result register can take a beat.
//  Each event passes the input register, then the result register.
//  The status update is a single compare, decrement or increment per register.
//  Reset enables monitor mode, zeroes all other state and loads the register
//  defaults; no beat is held. A stalled output holds its beat; the input
//  keeps accepting until both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module health_restart_supervisor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // report_valid, target_up, fail_streak, success_time, fail_time,
    // now_time, enable_value, zero pad
    input  wire logic [119:0]                    s_tdata,
    // action
    input  wire logic [2:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // mode, is_enabled, restart_pending, failure_count, restarts_done,
    // last_success, last_failure, last_restart, lockout_time, zero pad
    output logic [167:0]                         m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [hrs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hrs_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    status_t  core_status;
    status_t  m_status;

    always_comb
    begin
        s_item.action       = s_tuser;
        s_item.report_valid = s_tdata[0];
        s_item.target_up    = s_tdata[1];
        s_item.fail_streak  = s_tdata[17:2];
        s_item.success_time = s_tdata[49:18];
        s_item.fail_time    = s_tdata[81:50];
        s_item.now_time     = s_tdata[113:82];
        s_item.enable_value = s_tdata[114];
    end

    hrs_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    hrs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (item_valid && advance),
        .item      (item),
        .status    (core_status)
    );

    hrs_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_status (core_status),
        .advance   (advance),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_status  (m_status)
    );

    always_comb
    begin
        m_tdata          = '0;
        m_tdata[2:0]     = m_status.mode;
        m_tdata[3]       = m_status.is_enabled;
        m_tdata[4]       = m_status.restart_pending;
        m_tdata[20:5]    = m_status.failure_count;
        m_tdata[36:21]   = m_status.restarts_done;
        m_tdata[68:37]   = m_status.last_success;
        m_tdata[100:69]  = m_status.last_failure;
        m_tdata[132:101] = m_status.last_restart;
        m_tdata[164:133] = m_status.lockout_time;
    end

    // A pending restart request always goes with the restart required mode.
    a_pending_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_status.restart_pending) |-> (m_status.mode == MODE_RESTART))
        else $error("restart pending outside restart required mode");

    // An empty result register never blocks the input side.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

    // The restart count carried by the result never goes down.
    a_restarts_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) ##1 m_tvalid
            |-> m_status.restarts_done >= $past(m_status.restarts_done))
        else $error("restart count decreased");

endmodule

`default_nettype wire

### design/hrs_in_reg.sv
// ----------------------------------------------------------------------------
// hrs_in_reg
// Input register stage: holds one accepted beat until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hrs_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire hrs_pkg::in_item_t s_item,
    input  wire logic              advance,
    output logic                   item_valid,
    output hrs_pkg::in_item_t      item
);
    import hrs_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### design/hrs_core.sv
// ----------------------------------------------------------------------------
// hrs_core
// Supervisor state, configuration registers and the per-event update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module hrs_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [hrs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hrs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                           step,
    input  wire hrs_pkg::in_item_t              item,
    output hrs_pkg::status_t                    status
);
    import hrs_pkg::*;

    logic [7:0]  threshold_reg;
    logic [31:0] boot_delay_reg;
    logic [7:0]  max_restarts_reg;

    mode_t       mode_reg,          mode_next;
    logic        enable_reg,        enable_next;
    logic        pending_reg,       pending_next;
    logic [15:0] failures_reg,      failures_next;
    logic [15:0] restart_total_reg, restart_total_next;
    logic [31:0] cooldown_reg,      cooldown_next;
    logic [31:0] success_stamp_reg, success_stamp_next;
    logic [31:0] failure_stamp_reg, failure_stamp_next;
    logic [31:0] restart_stamp_reg, restart_stamp_next;
    logic [31:0] lockout_stamp_reg, lockout_stamp_next;

    logic [31:0] cooldown_dec;
    logic        at_threshold;
    logic        at_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= RESET_FAILURE_THRESHOLD;
            boot_delay_reg   <= RESET_BOOT_DELAY;
            max_restarts_reg <= RESET_MAX_RESTARTS;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FAILURE_THRESHOLD: threshold_reg    <= cfg_data[7:0];
                CFG_BOOT_DELAY:        boot_delay_reg   <= cfg_data;
                CFG_MAX_RESTARTS:      max_restarts_reg <= cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    assign cooldown_dec = (cooldown_reg != 32'd0) ? cooldown_reg - 32'd1 : 32'd0;
    assign at_threshold = item.fail_streak >= {8'd0, threshold_reg};
    assign at_limit     = restart_total_reg >= {8'd0, max_restarts_reg};

    always_comb
    begin
        mode_next          = mode_reg;
        enable_next        = enable_reg;
        pending_next       = pending_reg;
        failures_next      = failures_reg;
        restart_total_next = restart_total_reg;
        cooldown_next      = cooldown_reg;
        success_stamp_next = success_stamp_reg;
        failure_stamp_next = failure_stamp_reg;
        restart_stamp_next = restart_stamp_reg;
        lockout_stamp_next = lockout_stamp_reg;

        unique case (item.action)
            ACT_REPORT:
            begin
                // Reports are ignored while a restart is underway.
                if (enable_reg && item.report_valid &&
                    mode_reg != MODE_RESTART && mode_reg != MODE_COOLDOWN)
                begin
                    if (item.target_up)
                    begin
                        failures_next      = 16'd0;
                        success_stamp_next = item.success_time;
                        mode_next          = MODE_MONITOR;
                    end
                    else
                    begin
                        failures_next      = item.fail_streak;
                        failure_stamp_next = item.fail_time;
                        if (at_threshold)
                        begin
                            if (at_limit)
                            begin
                                if (mode_reg != MODE_LOCKED)
                                begin
                                    lockout_stamp_next = item.now_time;
                                    mode_next          = MODE_LOCKED;
                                end
                            end
                            else if (!pending_reg)
                            begin
                                pending_next = 1'b1;
                                mode_next    = MODE_RESTART;
                            end
                        end
                    end
                end
            end
            ACT_RESTART_DONE:
            begin
                if (pending_reg)
                begin
                    pending_next  = 1'b0;
                    failures_next = 16'd0;
                    if (restart_total_reg != RESTART_TOTAL_MAX)
                    begin
                        restart_total_next = restart_total_reg + 16'd1;
                    end
                    restart_stamp_next = item.now_time;
                    cooldown_next      = boot_delay_reg;
                    mode_next          = MODE_COOLDOWN;
                end
            end
            ACT_TICK:
            begin
                if (mode_reg == MODE_COOLDOWN)
                begin
                    cooldown_next = cooldown_dec;
                    if (cooldown_dec == 32'd0)
                    begin
                        mode_next = enable_reg ? MODE_MONITOR : MODE_IDLE;
                    end
                end
            end
            ACT_SET_ENABLE:
            begin
                if (item.enable_value != enable_reg)
                begin
                    enable_next   = item.enable_value;
                    cooldown_next = 32'd0;
                    pending_next  = 1'b0;
                    failures_next = 16'd0;
                    mode_next     = item.enable_value ? MODE_MONITOR : MODE_IDLE;
                end
            end
            ACT_RESET:
            begin
                cooldown_next = 32'd0;
                pending_next  = 1'b0;
                failures_next = 16'd0;
                mode_next     = enable_reg ? MODE_MONITOR : MODE_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_MONITOR;
            enable_reg        <= 1'b1;
            pending_reg       <= 1'b0;
            failures_reg      <= 16'd0;
            restart_total_reg <= 16'd0;
            cooldown_reg      <= 32'd0;
            success_stamp_reg <= 32'd0;
            failure_stamp_reg <= 32'd0;
            restart_stamp_reg <= 32'd0;
            lockout_stamp_reg <= 32'd0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            enable_reg        <= enable_next;
            pending_reg       <= pending_next;
            failures_reg      <= failures_next;
            restart_total_reg <= restart_total_next;
            cooldown_reg      <= cooldown_next;
            success_stamp_reg <= success_stamp_next;
            failure_stamp_reg <= failure_stamp_next;
            restart_stamp_reg <= restart_stamp_next;
            lockout_stamp_reg <= lockout_stamp_next;
        end
    end

    always_comb
    begin
        status.mode            = mode_next;
        status.is_enabled      = enable_next;
        status.restart_pending = pending_next;
        status.failure_count   = failures_next;
        status.restarts_done   = restart_total_next;
        status.last_success    = success_stamp_next;
        status.last_failure    = failure_stamp_next;
        status.last_restart    = restart_stamp_next;
        status.lockout_time    = lockout_stamp_next;
    end

endmodule

`default_nettype wire

### design/hrs_out_reg.sv
// ----------------------------------------------------------------------------
// hrs_out_reg
// Result register: holds the status beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hrs_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire hrs_pkg::status_t in_status,
    output logic                  advance,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output hrs_pkg::status_t      m_status
);
    import hrs_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    status_t status_reg;

    assign advance    = !valid_reg || m_ready;
    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            status_reg <= in_status;
        end
    end

    assign m_valid  = valid_reg;
    assign m_status = status_reg;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for health_restart_supervisor. Events are driven on the
// input stream with random gaps while the status stream is stalled at random.
// A model of the supervisor kept in the bench predicts the status beat for
// each accepted event, and every beat is compared with it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import hrs_pkg::*;

    localparam int         CYCLE_LIMIT       = 400000;
    localparam int         MAX_PRINTED       = 40;
    localparam int         DRAIN_CYCLES      = 4;
    localparam logic [2:0] ACT_UNDEF_FIRST   = 3'd5;
    localparam logic [2:0] ACT_UNDEF_LAST    = 3'd7;
    localparam logic [7:0] RESTART_COUNT_TOP = 8'hFF;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // report_valid, target_up, fail_streak, success_time, fail_time,
    // now_time, enable_value, zero pad
    logic [119:0]           s_tdata   = '0;
    // action
    logic [2:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // mode, is_enabled, restart_pending, failure_count, restarts_done,
    // last_success, last_failure, last_restart, lockout_time, zero pad
    logic [167:0]           m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Register copies and supervisor state as the bench sees them.
    logic [7:0]  cfg_threshold    = RESET_FAILURE_THRESHOLD;
    logic [31:0] cfg_boot_delay   = RESET_BOOT_DELAY;
    logic [7:0]  cfg_max_restarts = RESET_MAX_RESTARTS;

    mode_t       sup_mode      = MODE_MONITOR;
    logic        sup_enabled   = 1'b1;
    logic        sup_pending   = 1'b0;
    logic [15:0] sup_failures  = '0;
    logic [15:0] sup_restarts  = '0;
    logic [31:0] sup_cooldown  = '0;
    logic [31:0] stamp_success = '0;
    logic [31:0] stamp_failure = '0;
    logic [31:0] stamp_restart = '0;
    logic [31:0] stamp_lockout = '0;

    status_t due_status[$];
    int      acted_events = 0;
    int      error_count  = 0;
    int      cycle_count  = 0;
    bit      tx_gaps_on   = 1'b1;
    bit      rx_gaps_on   = 1'b1;
    int      rx_wait      = 0;
    int      rx_hold      = 0;

    health_restart_supervisor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Supervisor model
    // ------------------------------------------------------------------------
    function automatic void soft_restart();
        sup_cooldown = '0;
        sup_pending  = 1'b0;
        sup_failures = '0;
        if (sup_enabled)
            sup_mode = MODE_MONITOR;
        else
            sup_mode = MODE_IDLE;
    endfunction

    function automatic status_t advance_supervisor(in_item_t ev);
        status_t st;
        case (ev.action)
            ACT_REPORT:
            begin
                if (sup_enabled && ev.report_valid &&
                    sup_mode != MODE_RESTART && sup_mode != MODE_COOLDOWN)
                begin
                    acted_events++;
                    if (ev.target_up)
                    begin
                        sup_failures  = '0;
                        stamp_success = ev.success_time;
                        sup_mode      = MODE_MONITOR;
                    end
                    else
                    begin
                        sup_failures  = ev.fail_streak;
                        stamp_failure = ev.fail_time;
                        if (sup_failures >= cfg_threshold)
                        begin
                            if (sup_restarts >= cfg_max_restarts)
                            begin
                                // Staying locked out keeps the first stamp.
                                if (sup_mode != MODE_LOCKED)
                                begin
                                    stamp_lockout = ev.now_time;
                                    sup_mode      = MODE_LOCKED;
                                end
                            end
                            else if (!sup_pending)
                            begin
                                sup_pending = 1'b1;
                                sup_mode    = MODE_RESTART;
                            end
                        end
                    end
                end
            end
            ACT_RESTART_DONE:
            begin
                if (sup_pending)
                begin
                    acted_events++;
                    sup_pending  = 1'b0;
                    sup_failures = '0;
                    if (sup_restarts != RESTART_TOTAL_MAX)
                        sup_restarts++;
                    stamp_restart = ev.now_time;
                    sup_cooldown  = cfg_boot_delay;
                    sup_mode      = MODE_COOLDOWN;
                end
            end
            ACT_TICK:
            begin
                if (sup_mode == MODE_COOLDOWN)
                begin
                    acted_events++;
                    // A zero delay ends the cooldown on the first tick.
                    if (sup_cooldown != 0)
                        sup_cooldown--;
                    if (sup_cooldown == 0)
                    begin
                        if (sup_enabled)
                            sup_mode = MODE_MONITOR;
                        else
                            sup_mode = MODE_IDLE;
                    end
                end
            end
            ACT_SET_ENABLE:
            begin
                if (ev.enable_value != sup_enabled)
                begin
                    acted_events++;
                    sup_enabled = ev.enable_value;
                    soft_restart();
                end
            end
            ACT_RESET:
            begin
                acted_events++;
                soft_restart();
            end
            default:
            begin
            end
        endcase
        st.mode            = sup_mode;
        st.is_enabled      = sup_enabled;
        st.restart_pending = sup_pending;
        st.failure_count   = sup_failures;
        st.restarts_done   = sup_restarts;
        st.last_success    = stamp_success;
        st.last_failure    = stamp_failure;
        st.last_restart    = stamp_restart;
        st.lockout_time    = stamp_lockout;
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // Status side
    // ------------------------------------------------------------------------
    task automatic note_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            note_error($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    initial
    begin : status_checker
        status_t want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                rx_wait = rx_gaps_on ? $urandom_range(0, 10) : 0;
                if (due_status.size() == 0)
                    note_error("status beat with no event waiting");
                else
                begin
                    want = due_status.pop_front();
                    check_field("mode", 32'(want.mode), 32'(m_tdata[2:0]));
                    check_field("is_enabled", 32'(want.is_enabled), 32'(m_tdata[3]));
                    check_field("restart_pending", 32'(want.restart_pending),
                                32'(m_tdata[4]));
                    check_field("failure_count", 32'(want.failure_count),
                                32'(m_tdata[20:5]));
                    check_field("restarts_done", 32'(want.restarts_done),
                                32'(m_tdata[36:21]));
                    check_field("last_success", want.last_success, m_tdata[68:37]);
                    check_field("last_failure", want.last_failure, m_tdata[100:69]);
                    check_field("last_restart", want.last_restart, m_tdata[132:101]);
                    check_field("lockout_time", want.lockout_time, m_tdata[164:133]);
                end
            end
        end
    end

    // A long hold takes precedence over the per-beat stall.
    initial
    begin : status_receiver
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Event side
    // ------------------------------------------------------------------------
    task automatic send_event(in_item_t ev);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.action;
        s_tdata  <= {5'd0, ev.enable_value, ev.now_time, ev.fail_time,
                     ev.success_time, ev.fail_streak, ev.target_up, ev.report_valid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due_status.push_back(advance_supervisor(ev));
    endtask

    function automatic in_item_t random_event(logic [2:0] act);
        in_item_t ev;
        ev.action       = act;
        ev.report_valid = 1'($urandom_range(0, 1));
        ev.target_up    = 1'($urandom_range(0, 1));
        ev.fail_streak  = 16'($urandom);
        ev.success_time = $urandom;
        ev.fail_time    = $urandom;
        ev.now_time     = $urandom;
        ev.enable_value = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    task automatic send_action(logic [2:0] act);
        send_event(random_event(act));
    endtask

    task automatic send_report(bit valid, bit up, logic [15:0] streak);
        in_item_t ev;
        ev              = random_event(ACT_REPORT);
        ev.report_valid = valid;
        ev.target_up    = up;
        ev.fail_streak  = streak;
        send_event(ev);
    endtask

    task automatic send_enable(bit en);
        in_item_t ev;
        ev              = random_event(ACT_SET_ENABLE);
        ev.enable_value = en;
        send_event(ev);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (due_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] thr, logic [31:0] delay, logic [7:0] limit);
        wait_for_results();
        write_reg(CFG_FAILURE_THRESHOLD, {24'd0, thr});
        write_reg(CFG_BOOT_DELAY, delay);
        write_reg(CFG_MAX_RESTARTS, {24'd0, limit});
        cfg_threshold    = thr;
        cfg_boot_delay   = delay;
        cfg_max_restarts = limit;
    endtask

    // Mostly failure episodes that climb to the threshold, get restarted and
    // cool down; the rest is random events, enable changes and resets.
    task automatic run_traffic(int target);
        int          goal;
        int          pick;
        int          n;
        logic [15:0] streak;
        goal = acted_events + target;
        while (acted_events < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                repeat ($urandom_range(0, 2)) send_report(1'b1, 1'b1, 16'($urandom));
                n = $urandom_range(1, 3);
                for (int i = n - 1; i >= 0; i--)
                begin
                    if ($urandom_range(0, 4) == 0)
                        streak = 16'($urandom);
                    else if (cfg_threshold >= i)
                        streak = 16'(int'(cfg_threshold) - i);
                    else
                        streak = '0;
                    send_report($urandom_range(0, 15) != 0, 1'b0, streak);
                end
                if ($urandom_range(0, 9) != 0)
                    send_action(ACT_RESTART_DONE);
                if (cfg_boot_delay < 8)
                    n = int'(cfg_boot_delay) + $urandom_range(0, 2);
                else
                    n = $urandom_range(1, 3);
                repeat (n) send_action(ACT_TICK);
            end
            else if (pick < 80)
                send_event(random_event(3'($urandom_range(0, 7))));
            else if (pick < 88)
                send_enable(sup_enabled ? ($urandom_range(0, 2) != 0)
                                        : ($urandom_range(0, 3) != 0));
            else if (pick < 94)
                send_action(ACT_RESET);
            else if (pick[0])
                send_action(ACT_RESTART_DONE);
            else
                send_action(ACT_TICK);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_events();
        in_item_t ev;
        for (int a = int'(ACT_UNDEF_FIRST); a <= int'(ACT_UNDEF_LAST); a++)
            send_action(a[2:0]);
        send_report(1'b0, 1'b0, 16'hFFFF);
        ev              = random_event(ACT_REPORT);
        ev.report_valid = 1'b1;
        ev.target_up    = 1'b1;
        ev.success_time = '1;
        send_event(ev);
        ev              = random_event(ACT_REPORT);
        ev.report_valid = 1'b1;
        ev.target_up    = 1'b0;
        ev.fail_streak  = 16'd2;
        ev.fail_time    = '0;
        send_event(ev);
        send_report(1'b1, 1'b0, 16'hFFFF);
        // Requested restart: reports and ticks are ignored until it completes.
        send_report(1'b1, 1'b1, 16'd0);
        send_action(ACT_TICK);
        ev          = random_event(ACT_RESTART_DONE);
        ev.now_time = '1;
        send_event(ev);
        send_action(ACT_TICK);
        send_report(1'b1, 1'b0, 16'hFFFF);
        send_action(ACT_RESET);
        send_action(ACT_RESTART_DONE);
        send_enable(1'b1);
        send_enable(1'b0);
        send_report(1'b1, 1'b0, 16'hFFFF);
        send_action(ACT_TICK);
        send_enable(1'b1);
    endtask

    task automatic test_limits_and_edges();
        in_item_t ev;
        set_config(RESET_FAILURE_THRESHOLD, 32'd0, RESET_MAX_RESTARTS);
        send_report(1'b1, 1'b0, 16'd3);
        ev          = random_event(ACT_RESTART_DONE);
        ev.now_time = '0;
        send_event(ev);
        send_action(ACT_TICK);
        set_config(RESET_FAILURE_THRESHOLD, 32'd0, 8'd0);
        send_report(1'b1, 1'b0, 16'd5);
        send_report(1'b1, 1'b0, 16'd6);
        send_report(1'b1, 1'b1, 16'd0);
        set_config(8'd0, 32'd0, 8'd0);
        send_report(1'b1, 1'b0, 16'd0);
        send_action(ACT_RESET);
    endtask

    task automatic test_random_phases();
        set_config(8'd3, 32'd2, 8'd200);
        run_traffic(250);
        set_config(8'd0, 32'd0, sup_restarts[7:0] + 8'd4);
        rx_gaps_on = 1'b0;
        run_traffic(200);
        set_config(8'd255, 32'hFFFF_FFFF, 8'd255);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b1;
        run_traffic(150);
        set_config(8'($urandom_range(1, 8)), $urandom_range(1, 6), 8'd150);
        rx_gaps_on = 1'b0;
        run_traffic(200);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        wait_for_results();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        rx_hold    = 120;
        run_traffic(30);
        // The sender stops here until the whole backlog has been delivered.
        wait_for_results();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // Drive the restart count up to the largest limit, then into lockout.
    task automatic test_restart_storm();
        set_config(8'd1, 32'd0, RESTART_COUNT_TOP);
        tx_gaps_on = 1'b0;
        if (!sup_enabled)
            send_enable(1'b1);
        else
            send_action(ACT_RESET);
        while (sup_restarts < {8'd0, RESTART_COUNT_TOP})
        begin
            send_report(1'b1, 1'b0, 16'($urandom_range(1, 16'hFFFF)));
            send_action(ACT_RESTART_DONE);
            send_action(ACT_TICK);
        end
        send_report(1'b1, 1'b0, 16'hFFFF);
        send_report(1'b1, 1'b0, 16'd1);
        send_action(ACT_RESTART_DONE);
        tx_gaps_on = 1'b1;
    endtask

    initial
    begin : main_sequence
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_events();
        test_limits_and_edges();
        test_random_phases();
        test_output_backpressure();
        test_restart_storm();
        wait_for_results();
        repeat (8) @(posedge clk);
        if (error_count == 0 && due_status.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ERROR: cycle limit reached with %0d beats outstanding", due_status.size());
        $display("testbench: done, errors");
        $finish;
    end

endmodule
